// ===== hw/rtl/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Countdown timer package
// Shared types, codes and constants of the countdown timer block.
// ----------------------------------------------------------------------------
package cdt_pkg;

   // Widths of the time values and of the interface fields
   localparam int SEC_W      = 14;
   localparam int CMD_W      = 3;
   localparam int DELTA_W    = 16;
   localparam int MODE_W     = 2;
   localparam int MIN_W      = 8;
   localparam int SEC_PART_W = 6;
   localparam int CSR_IDX_W  = 2;

   // Reset values of the configuration registers
   localparam logic [SEC_W-1:0] DEFAULT_RESET = SEC_W'(300);
   localparam logic [SEC_W-1:0] MIN_RESET     = SEC_W'(0);
   localparam logic [SEC_W-1:0] MAX_RESET     = SEC_W'(5999);

   // Timer modes
   typedef enum logic [MODE_W-1:0] {
      MODE_SETTING   = 2'd0,
      MODE_RUNNING   = 2'd1,
      MODE_PAUSED    = 2'd2,
      MODE_COMPLETED = 2'd3
   } mode_type;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 3'd0,
      CMD_START  = 3'd1,
      CMD_PAUSE  = 3'd2,
      CMD_RESUME = 3'd3,
      CMD_RESET  = 3'd4,
      CMD_ADJUST = 3'd5
   } cmd_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEFAULT = 2'd0,
      CSR_MIN     = 2'd1,
      CSR_MAX     = 2'd2
   } csr_idx_type;

endpackage

// ===== hw/rtl/cdt_ifs.sv =====
// ----------------------------------------------------------------------------
// Countdown timer channels
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------

// Command channel
interface cdt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [cdt_pkg::CMD_W-1:0]            cmd;
   logic signed [cdt_pkg::DELTA_W-1:0]   delta;

   modport source (output valid, output cmd, output delta, input ready);
   modport sink (input valid, input cmd, input delta, output ready);
endinterface

// Result channel
interface cdt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [cdt_pkg::MODE_W-1:0]           mode;
   logic [cdt_pkg::MODE_W-1:0]           prev_mode;
   logic [cdt_pkg::SEC_W-1:0]            shown_seconds;
   logic [cdt_pkg::SEC_W-1:0]            preset_seconds;
   logic [cdt_pkg::MIN_W-1:0]            shown_minutes;
   logic [cdt_pkg::SEC_PART_W-1:0]       shown_sec_part;
   logic                                 rejected;
   logic                                 finished_now;

   modport source (output valid, output mode, output prev_mode, output shown_seconds,
                   output preset_seconds, output shown_minutes, output shown_sec_part,
                   output rejected, output finished_now, input ready);
   modport sink (input valid, input mode, input prev_mode, input shown_seconds,
                 input preset_seconds, input shown_minutes, input shown_sec_part,
                 input rejected, input finished_now, output ready);
endinterface

// Register write channel
interface cdt_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [cdt_pkg::CSR_IDX_W-1:0]        index;
   logic [cdt_pkg::SEC_W-1:0]            data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/cdt_display.sv =====
// ----------------------------------------------------------------------------
// Countdown timer display split
// Splits a seconds count into saturated minutes and the seconds part.
// ----------------------------------------------------------------------------
module cdt_display (
   input  logic [cdt_pkg::SEC_W-1:0]      seconds,
   output logic [cdt_pkg::MIN_W-1:0]      minutes,
   output logic [cdt_pkg::SEC_PART_W-1:0] sec_part
);

   // ceil(2^20 / 60): exact quotient for every 14-bit count
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 15;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(17477);
   localparam int PROD_W      = cdt_pkg::SEC_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam int SIXTY_W     = QUOT_W + 6;

   logic [PROD_W-1:0]  product;
   logic [QUOT_W-1:0]  quotient;
   logic [SIXTY_W-1:0] quot_x60;
   logic [SIXTY_W-1:0] remainder;

   // Divide by sixty through the reciprocal
   assign product  = PROD_W'(seconds) * PROD_W'(RECIP);
   assign quotient = product[PROD_W-1:RECIP_SHIFT];

   // Remainder from the quotient: q*60 = q*64 - q*4
   assign quot_x60  = {quotient, 6'b0} - {4'b0, quotient, 2'b0};
   assign remainder = SIXTY_W'(seconds) - quot_x60;
   assign sec_part  = remainder[cdt_pkg::SEC_PART_W-1:0];

   // Saturate minutes at the top of the field
   always_comb begin
      if (quotient > QUOT_W'(255)) begin
         minutes = '1;
      end else begin
         minutes = quotient[cdt_pkg::MIN_W-1:0];
      end
   end

endmodule

// ===== hw/rtl/countdown_timer_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// Countdown timer unit
// Command-driven countdown timer with setting, running, paused and completed
// modes; one result beat for every command beat.
// ----------------------------------------------------------------------------
// A command beat waits in the command register and moves into the result register
// when the result register is free or draining; a stall on the result side holds
// it in the command register. Throughput: one command per cycle unless the result
// side stalls; the mode and time update is a single pass.
// Reset: mode returns to setting, preset and remaining time load 300 seconds,
// the limit registers load 0 and 5999, and both channel stages empty.
module countdown_timer_fsm_unit (
   input  logic            clock,
   input  logic            reset,
   cdt_req_if.sink         req_chan,
   cdt_rsp_if.source       rsp_chan,
   cdt_csr_if.sink         csr_chan
);

   localparam int SUM_W = cdt_pkg::SEC_W + 4;

   // Configuration registers
   logic [cdt_pkg::SEC_W-1:0] default_ff, min_ff, max_ff;

   // Timer state
   cdt_pkg::mode_type         mode_ff, mode_in;
   logic [cdt_pkg::SEC_W-1:0] preset_ff, preset_in;
   logic [cdt_pkg::SEC_W-1:0] remain_ff, remain_in;

   // Command stage
   logic                               cmd_valid_ff, cmd_valid_in;
   logic [cdt_pkg::CMD_W-1:0]          cmd_ff;
   logic signed [cdt_pkg::DELTA_W-1:0] delta_ff;

   // Result stage
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [cdt_pkg::MODE_W-1:0]         mode_out_ff, prev_out_ff;
   logic [cdt_pkg::SEC_W-1:0]          shown_out_ff, preset_out_ff;
   logic [cdt_pkg::MIN_W-1:0]          minutes_out_ff;
   logic [cdt_pkg::SEC_PART_W-1:0]     sec_part_out_ff;
   logic                               rejected_out_ff, finished_out_ff;

   // Handshake control
   logic rsp_free, advance, take;

   // Update logic
   logic                               rejected, finished;
   logic [cdt_pkg::SEC_W-1:0]          shown;
   logic [cdt_pkg::MIN_W-1:0]          minutes;
   logic [cdt_pkg::SEC_PART_W-1:0]     sec_part;
   logic [cdt_pkg::SEC_W-1:0]          adj_base;
   logic signed [SUM_W-1:0]            adj_sum;
   logic [cdt_pkg::SEC_W-1:0]          adj_value;

   // Move a beat on when the result register is free or being drained
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = cmd_valid_ff && rsp_free;
   assign req_chan.ready = !cmd_valid_ff || rsp_free;
   assign take           = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign cmd_valid_in = take ? 1'b1 : (advance ? 1'b0 : cmd_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // Hold configuration, write on a register beat
   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff <= cdt_pkg::DEFAULT_RESET;
         min_ff     <= cdt_pkg::MIN_RESET;
         max_ff     <= cdt_pkg::MAX_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (cdt_pkg::csr_idx_type'(csr_chan.index))
            cdt_pkg::CSR_DEFAULT: default_ff <= csr_chan.data;
            cdt_pkg::CSR_MIN:     min_ff     <= csr_chan.data;
            cdt_pkg::CSR_MAX:     max_ff     <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   // Clamped adjust: lower limit tested first
   assign adj_base = (mode_ff == cdt_pkg::MODE_SETTING) ? preset_ff : remain_ff;
   assign adj_sum  = $signed({4'b0, adj_base}) + SUM_W'(delta_ff);
   always_comb begin
      if (adj_sum < $signed({4'b0, min_ff})) begin
         adj_value = min_ff;
      end else if (adj_sum > $signed({4'b0, max_ff})) begin
         adj_value = max_ff;
      end else begin
         adj_value = adj_sum[cdt_pkg::SEC_W-1:0];
      end
   end

   // Next mode and times for the command in the command register
   always_comb begin
      mode_in   = mode_ff;
      preset_in = preset_ff;
      remain_in = remain_ff;
      rejected  = 1'b0;
      finished  = 1'b0;
      unique case (cdt_pkg::cmd_type'(cmd_ff))
         cdt_pkg::CMD_TICK: begin
            if (mode_ff == cdt_pkg::MODE_RUNNING && remain_ff != '0) begin
               remain_in = remain_ff - cdt_pkg::SEC_W'(1);
               if (remain_ff == cdt_pkg::SEC_W'(1)) begin
                  mode_in  = cdt_pkg::MODE_COMPLETED;
                  finished = 1'b1;
               end
            end
         end
         cdt_pkg::CMD_START: begin
            if (mode_ff == cdt_pkg::MODE_SETTING) begin
               remain_in = preset_ff;
               mode_in   = cdt_pkg::MODE_RUNNING;
            end else begin
               rejected = 1'b1;
            end
         end
         cdt_pkg::CMD_PAUSE: begin
            if (mode_ff == cdt_pkg::MODE_RUNNING) begin
               mode_in = cdt_pkg::MODE_PAUSED;
            end else begin
               rejected = 1'b1;
            end
         end
         cdt_pkg::CMD_RESUME: begin
            if (mode_ff == cdt_pkg::MODE_PAUSED) begin
               mode_in = cdt_pkg::MODE_RUNNING;
            end else begin
               rejected = 1'b1;
            end
         end
         cdt_pkg::CMD_RESET: begin
            mode_in   = cdt_pkg::MODE_SETTING;
            preset_in = default_ff;
            remain_in = default_ff;
         end
         cdt_pkg::CMD_ADJUST: begin
            if (mode_ff == cdt_pkg::MODE_SETTING) begin
               preset_in = adj_value;
            end else if (mode_ff == cdt_pkg::MODE_PAUSED) begin
               remain_in = adj_value;
            end
         end
         default: begin
         end
      endcase
   end

   // Pick the displayed time for the new mode
   always_comb begin
      unique case (mode_in)
         cdt_pkg::MODE_SETTING:   shown = preset_in;
         cdt_pkg::MODE_COMPLETED: shown = '0;
         default:                 shown = remain_in;
      endcase
   end

   cdt_display u_display (
      .seconds  (shown),
      .minutes  (minutes),
      .sec_part (sec_part)
   );

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= cdt_pkg::MODE_SETTING;
         preset_ff    <= cdt_pkg::DEFAULT_RESET;
         remain_ff    <= cdt_pkg::DEFAULT_RESET;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff   <= mode_in;
            preset_ff <= preset_in;
            remain_ff <= remain_in;
         end
      end
   end

   // Capture the command beat
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff   <= req_chan.cmd;
         delta_ff <= req_chan.delta;
      end
   end

   // Capture the result beat
   always_ff @(posedge clock) begin
      if (advance) begin
         mode_out_ff     <= mode_in;
         prev_out_ff     <= mode_ff;
         shown_out_ff    <= shown;
         preset_out_ff   <= preset_in;
         minutes_out_ff  <= minutes;
         sec_part_out_ff <= sec_part;
         rejected_out_ff <= rejected;
         finished_out_ff <= finished;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.mode           = mode_out_ff;
   assign rsp_chan.prev_mode      = prev_out_ff;
   assign rsp_chan.shown_seconds  = shown_out_ff;
   assign rsp_chan.preset_seconds = preset_out_ff;
   assign rsp_chan.shown_minutes  = minutes_out_ff;
   assign rsp_chan.shown_sec_part = sec_part_out_ff;
   assign rsp_chan.rejected       = rejected_out_ff;
   assign rsp_chan.finished_now   = finished_out_ff;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Countdown timer unit testbench
// Drives command beats, register writes and result back-pressure on the
// valid/ready channels of the countdown timer. An in-bench timer model
// predicts every result beat, and each beat is compared field by field. A
// short table of directed commands comes first. Random countdown runs
// mixed with stray commands follow, over several clamp and default
// settings and three idling patterns.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int ITEMS_PER_SETTING = 66;
   localparam int SETTING_COUNT     = 6;
   localparam int DRAIN_CYCLES      = 8;
   localparam int DIRECTED_COUNT    = 26;

   // Command codes the block does not define
   localparam logic [cdt_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [cdt_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   localparam logic signed [cdt_pkg::DELTA_W-1:0] DELTA_MOST_NEG = 16'sh8000;
   localparam logic signed [cdt_pkg::DELTA_W-1:0] DELTA_MOST_POS = 16'sh7FFF;
   localparam logic [cdt_pkg::SEC_W-1:0]          SEC_ALL_ONES   = '1;

   typedef struct packed {
      cdt_pkg::mode_type              mode;
      cdt_pkg::mode_type              prev_mode;
      logic [cdt_pkg::SEC_W-1:0]      shown_seconds;
      logic [cdt_pkg::SEC_W-1:0]      preset_seconds;
      logic [cdt_pkg::MIN_W-1:0]      shown_minutes;
      logic [cdt_pkg::SEC_PART_W-1:0] shown_sec_part;
      logic                           rejected;
      logic                           finished_now;
   } timer_view_type;

   typedef struct packed {
      logic [cdt_pkg::CMD_W-1:0]          cmd;
      logic signed [cdt_pkg::DELTA_W-1:0] delta;
      logic                               typed;
      timer_view_type                     view;
   } stim_row_type;

   localparam timer_view_type NO_VIEW = '0;

   logic clock;
   logic reset;

   cdt_req_if req_bus ();
   cdt_rsp_if rsp_bus ();
   cdt_csr_if csr_bus ();

   countdown_timer_fsm_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Timer model state and its copy of the registers
   cdt_pkg::mode_type         tmr_mode;
   logic [cdt_pkg::SEC_W-1:0] tmr_preset;
   logic [cdt_pkg::SEC_W-1:0] tmr_remain;
   logic [cdt_pkg::SEC_W-1:0] cfg_default;
   logic [cdt_pkg::SEC_W-1:0] cfg_min;
   logic [cdt_pkg::SEC_W-1:0] cfg_max;

   timer_view_type expected_views [$];
   stim_row_type   issued_rows [$];
   int             fail_count   = 0;
   int             quiet_cycles = 0;
   int             items_sent   = 0;
   int             req_idle_pct = 0;
   int             rsp_idle_pct = 0;

   // Directed commands; a typed view is checked instead of the model's view
   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{cdt_pkg::CMD_TICK, 16'sd0, 1'b1,
        '{cdt_pkg::MODE_SETTING, cdt_pkg::MODE_SETTING,
          14'd300, 14'd300, 8'd5, 6'd0, 1'b0, 1'b0}},
      '{cdt_pkg::CMD_PAUSE, 16'sd0, 1'b1,
        '{cdt_pkg::MODE_SETTING, cdt_pkg::MODE_SETTING,
          14'd300, 14'd300, 8'd5, 6'd0, 1'b1, 1'b0}},
      '{cdt_pkg::CMD_RESUME, 16'sd0, 1'b1,
        '{cdt_pkg::MODE_SETTING, cdt_pkg::MODE_SETTING,
          14'd300, 14'd300, 8'd5, 6'd0, 1'b1, 1'b0}},
      '{cdt_pkg::CMD_ADJUST, DELTA_MOST_POS, 1'b1,
        '{cdt_pkg::MODE_SETTING, cdt_pkg::MODE_SETTING,
          14'd5999, 14'd5999, 8'd99, 6'd59, 1'b0, 1'b0}},
      '{cdt_pkg::CMD_ADJUST, DELTA_MOST_NEG, 1'b1,
        '{cdt_pkg::MODE_SETTING, cdt_pkg::MODE_SETTING,
          14'd0, 14'd0, 8'd0, 6'd0, 1'b0, 1'b0}},
      '{cdt_pkg::CMD_ADJUST, 16'sd61, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_START, 16'sd0, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_START, 16'sd0, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_ADJUST, 16'sd5, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_TICK, -16'sd1, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_PAUSE, 16'sd0, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_PAUSE, 16'sd0, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_ADJUST, -16'sd59, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_TICK, 16'sd0, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_RESUME, 16'sd0, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_TICK, 16'sd0, 1'b1,
        '{cdt_pkg::MODE_COMPLETED, cdt_pkg::MODE_RUNNING,
          14'd0, 14'd61, 8'd0, 6'd0, 1'b0, 1'b1}},
      '{cdt_pkg::CMD_TICK, 16'sd0, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_START, 16'sd0, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_ADJUST, 16'sd100, 1'b0, NO_VIEW},
      '{CMD_SPARE_6, -16'sd1, 1'b0, NO_VIEW},
      '{CMD_SPARE_7, 16'sh5555, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_RESET, 16'sd0, 1'b1,
        '{cdt_pkg::MODE_SETTING, cdt_pkg::MODE_COMPLETED,
          14'd300, 14'd300, 8'd5, 6'd0, 1'b0, 1'b0}},
      '{cdt_pkg::CMD_ADJUST, -16'sd300, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_START, 16'sd0, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_TICK, 16'sd0, 1'b0, NO_VIEW},
      '{cdt_pkg::CMD_RESET, 16'sd0, 1'b1,
        '{cdt_pkg::MODE_SETTING, cdt_pkg::MODE_RUNNING,
          14'd300, 14'd300, 8'd5, 6'd0, 1'b0, 1'b0}}
   };

   always #2 clock = ~clock;

   // Add a signed delta and hold the sum within the clamps, lower clamp first
   function automatic logic [cdt_pkg::SEC_W-1:0] clamp_time(
         input logic [cdt_pkg::SEC_W-1:0] base,
         input logic signed [cdt_pkg::DELTA_W-1:0] delta);
      int sum;
      sum = int'(base) + int'(delta);
      if (sum < int'(cfg_min))
         return cfg_min;
      if (sum > int'(cfg_max))
         return cfg_max;
      return cdt_pkg::SEC_W'(sum);
   endfunction

   // Apply one command to the timer model and return the view it shows
   function automatic timer_view_type advance_timer(
         input logic [cdt_pkg::CMD_W-1:0] cmd,
         input logic signed [cdt_pkg::DELTA_W-1:0] delta);
      timer_view_type            view;
      logic [cdt_pkg::SEC_W-1:0] shown;
      int                        mins;
      view = NO_VIEW;
      view.prev_mode = tmr_mode;
      case (cmd)
         cdt_pkg::CMD_TICK: begin
            if (tmr_mode == cdt_pkg::MODE_RUNNING && tmr_remain != '0) begin
               tmr_remain = tmr_remain - cdt_pkg::SEC_W'(1);
               if (tmr_remain == '0) begin
                  tmr_mode = cdt_pkg::MODE_COMPLETED;
                  view.finished_now = 1'b1;
               end
            end
         end
         cdt_pkg::CMD_START: begin
            if (tmr_mode == cdt_pkg::MODE_SETTING) begin
               tmr_remain = tmr_preset;
               tmr_mode   = cdt_pkg::MODE_RUNNING;
            end else begin
               view.rejected = 1'b1;
            end
         end
         cdt_pkg::CMD_PAUSE: begin
            if (tmr_mode == cdt_pkg::MODE_RUNNING)
               tmr_mode = cdt_pkg::MODE_PAUSED;
            else
               view.rejected = 1'b1;
         end
         cdt_pkg::CMD_RESUME: begin
            if (tmr_mode == cdt_pkg::MODE_PAUSED)
               tmr_mode = cdt_pkg::MODE_RUNNING;
            else
               view.rejected = 1'b1;
         end
         cdt_pkg::CMD_RESET: begin
            tmr_mode   = cdt_pkg::MODE_SETTING;
            tmr_preset = cfg_default;
            tmr_remain = cfg_default;
         end
         cdt_pkg::CMD_ADJUST: begin
            if (tmr_mode == cdt_pkg::MODE_SETTING)
               tmr_preset = clamp_time(tmr_preset, delta);
            else if (tmr_mode == cdt_pkg::MODE_PAUSED)
               tmr_remain = clamp_time(tmr_remain, delta);
         end
         default: begin
         end
      endcase
      if (tmr_mode == cdt_pkg::MODE_SETTING)
         shown = tmr_preset;
      else if (tmr_mode == cdt_pkg::MODE_COMPLETED)
         shown = '0;
      else
         shown = tmr_remain;
      mins = int'(shown) / 60;
      if (mins > 255)
         mins = 255;
      view.mode           = tmr_mode;
      view.shown_seconds  = shown;
      view.preset_seconds = tmr_preset;
      view.shown_minutes  = cdt_pkg::MIN_W'(mins);
      view.shown_sec_part = cdt_pkg::SEC_PART_W'(int'(shown) % 60);
      return view;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Track register writes and commands, check result beats, run the watchdog
   always @(posedge clock) begin
      timer_view_type want;
      stim_row_type   row;
      if (reset) begin
         tmr_mode    = cdt_pkg::MODE_SETTING;
         tmr_preset  = cdt_pkg::DEFAULT_RESET;
         tmr_remain  = cdt_pkg::DEFAULT_RESET;
         cfg_default = cdt_pkg::DEFAULT_RESET;
         cfg_min     = cdt_pkg::MIN_RESET;
         cfg_max     = cdt_pkg::MAX_RESET;
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (csr_bus.valid && csr_bus.ready) begin
            quiet_cycles = 0;
            case (csr_bus.index)
               cdt_pkg::CSR_DEFAULT: cfg_default = csr_bus.data;
               cdt_pkg::CSR_MIN:     cfg_min     = csr_bus.data;
               cdt_pkg::CSR_MAX:     cfg_max     = csr_bus.data;
               default: begin
               end
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            quiet_cycles = 0;
            row  = issued_rows.pop_front();
            want = advance_timer(req_bus.cmd, req_bus.delta);
            expected_views.push_back(row.typed ? row.view : want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            quiet_cycles = 0;
            if (expected_views.size() == 0) begin
               $error("result beat with no expectation waiting");
               fail_count++;
            end else begin
               want = expected_views.pop_front();
               check_field("mode", want.mode, rsp_bus.mode);
               check_field("prev_mode", want.prev_mode, rsp_bus.prev_mode);
               check_field("shown_seconds", want.shown_seconds, rsp_bus.shown_seconds);
               check_field("preset_seconds", want.preset_seconds, rsp_bus.preset_seconds);
               check_field("shown_minutes", want.shown_minutes, rsp_bus.shown_minutes);
               check_field("shown_sec_part", want.shown_sec_part, rsp_bus.shown_sec_part);
               check_field("rejected", want.rejected, rsp_bus.rejected);
               check_field("finished_now", want.finished_now, rsp_bus.finished_now);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("countdown_timer_fsm_unit test failed");
            $finish;
         end
      end
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Offer one command beat after a random gap; hold valid high on return
   task automatic send_row(input stim_row_type row);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      issued_rows.push_back(row);
      items_sent++;
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= row.cmd;
      req_bus.delta <= row.delta;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   task automatic send_cmd(input logic [cdt_pkg::CMD_W-1:0] cmd,
                           input logic signed [cdt_pkg::DELTA_W-1:0] delta);
      stim_row_type row;
      row.cmd   = cmd;
      row.delta = delta;
      row.typed = 1'b0;
      row.view  = NO_VIEW;
      send_row(row);
   endtask

   // Any code, any delta: covers the undefined commands and every delta bit
   task automatic send_noise();
      send_cmd(cdt_pkg::CMD_W'($urandom_range(0, 7)), cdt_pkg::DELTA_W'($urandom));
   endtask

   // Reload, trim the preset to a short time, start, then mostly tick
   task automatic run_countdown();
      int roll;
      int nudge;
      send_cmd(cdt_pkg::CMD_RESET, cdt_pkg::DELTA_W'($urandom));
      send_cmd(cdt_pkg::CMD_ADJUST, DELTA_MOST_NEG);
      send_cmd(cdt_pkg::CMD_ADJUST, cdt_pkg::DELTA_W'($urandom_range(0, 30)));
      send_cmd(cdt_pkg::CMD_START, cdt_pkg::DELTA_W'($urandom));
      repeat ($urandom_range(10, 50)) begin
         roll  = $urandom_range(0, 99);
         nudge = int'($urandom_range(0, 40)) - 20;
         if (roll < 70)
            send_cmd(cdt_pkg::CMD_TICK, cdt_pkg::DELTA_W'($urandom));
         else if (roll < 78)
            send_cmd(cdt_pkg::CMD_PAUSE, cdt_pkg::DELTA_W'($urandom));
         else if (roll < 86)
            send_cmd(cdt_pkg::CMD_RESUME, cdt_pkg::DELTA_W'($urandom));
         else if (roll < 94)
            send_cmd(cdt_pkg::CMD_ADJUST, cdt_pkg::DELTA_W'(nudge));
         else
            send_noise();
      end
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic wait_until_settled();
      req_bus.valid <= 1'b0;
      do
         @(negedge clock);
      while (expected_views.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input cdt_pkg::csr_idx_type index,
                            input logic [cdt_pkg::SEC_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
   endtask

   // Load default and clamps; the inverted pair and the all-ones default are deliberate
   task automatic load_clamp_plan(input int plan);
      logic [cdt_pkg::SEC_W-1:0] dflt;
      logic [cdt_pkg::SEC_W-1:0] lo;
      logic [cdt_pkg::SEC_W-1:0] hi;
      case (plan)
         0: begin
            dflt = cdt_pkg::DEFAULT_RESET;
            lo   = cdt_pkg::MIN_RESET;
            hi   = cdt_pkg::MAX_RESET;
         end
         1: begin dflt = '0; lo = '0; hi = '0; end
         2: begin dflt = 14'd15359; lo = '0; hi = 14'd15359; end
         3: begin dflt = SEC_ALL_ONES; lo = '0; hi = SEC_ALL_ONES; end
         4: begin dflt = 14'd100; lo = 14'd200; hi = 14'd50; end
         default: begin
            dflt = cdt_pkg::SEC_W'($urandom_range(0, 15359));
            lo   = cdt_pkg::SEC_W'($urandom_range(0, 200));
            hi   = cdt_pkg::SEC_W'($urandom_range(int'(lo), 15359));
         end
      endcase
      write_csr(cdt_pkg::CSR_DEFAULT, dflt);
      write_csr(cdt_pkg::CSR_MIN, lo);
      write_csr(cdt_pkg::CSR_MAX, hi);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      int first_item;
      clock          = 1'b0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= cdt_pkg::CMD_TICK;
      req_bus.delta <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= cdt_pkg::CSR_DEFAULT;
      csr_bus.data  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table under the first idling pattern
      req_idle_pct = 18;
      rsp_idle_pct = 76;
      foreach (directed_rows[i])
         send_row(directed_rows[i]);
      wait_until_settled();

      // Random runs: each idling pattern over every clamp plan
      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 76 : 0;
         rsp_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 18 : 0;
         for (int plan = 0; plan < SETTING_COUNT; plan++) begin
            load_clamp_plan(plan);
            first_item = items_sent;
            while (items_sent - first_item < ITEMS_PER_SETTING) begin
               if ($urandom_range(0, 99) < 80)
                  run_countdown();
               else
                  repeat ($urandom_range(1, 4)) send_noise();
            end
            wait_until_settled();
         end
      end

      // Let any stray beat show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("countdown_timer_fsm_unit test passed");
      else
         $display("countdown_timer_fsm_unit test failed");
      $finish;
   end

endmodule

// ===== countdown_timer_fsm_unit.f =====
hw/rtl/cdt_pkg.sv
hw/rtl/cdt_ifs.sv
hw/rtl/cdt_display.sv
hw/rtl/countdown_timer_fsm_unit.sv
bench/testbench.sv
